>>> hdl/gdds_pkg.sv
// ----------------------------------------------------------------------------
// gdds_pkg
// Shared widths, register indexes and types of the grid density diffusion
// stencil unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gdds_pkg;

    // Default grid capacity (interior cells per row and column)
    localparam int GRID_MAX_DEF = 256;

    // Field widths
    localparam int DENS_W     = 16;
    localparam int SIZE_W     = 9;
    localparam int GAIN_W     = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_INTERIOR_SIZE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_DIFFUSION_GAIN = 1'b1;

    // Register reset values and limits
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd64;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd2;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1638;

    // Which neighbors of a cell are interior and take part in the stencil
    typedef struct packed {
        logic left;
        logic right;
        logic up;
        logic down;
    } gdds_nbr_t;

endpackage

`default_nettype wire

>>> hdl/gdds_row_ram.sv
// ----------------------------------------------------------------------------
// gdds_row_ram
// Row store: one write port, two registered read ports, write-first on an
// address collision. A fill count marks the written prefix; entries past it
// read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module gdds_row_ram
    import gdds_pkg::*;
#(
    parameter int DEPTH  = GRID_MAX_DEF + 2,
    parameter int DATA_W = DENS_W
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [DATA_W-1:0]         wdata,
    input  wire logic                      re,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr_b,
    output logic      [DATA_W-1:0]         rdata_a,
    output logic      [DATA_W-1:0]         rdata_b
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;
    logic [FILL_W-1:0] waddr_ext;

    assign waddr_ext = FILL_W'(waddr);

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Track the written prefix; addresses are written in ascending runs from zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (we && (waddr_ext >= fill_reg)) begin
            fill_reg <= waddr_ext + FILL_W'(1);
        end
    end

    // Read ports: bypass a same-edge write, zero past the fill count
    always_ff @(posedge aclk) begin
        if (re) begin
            if (we && (waddr == raddr_a)) begin
                rdata_a_reg <= wdata;
            end else if (FILL_W'(raddr_a) >= fill_reg) begin
                rdata_a_reg <= '0;
            end else begin
                rdata_a_reg <= mem[raddr_a];
            end
            if (we && (waddr == raddr_b)) begin
                rdata_b_reg <= wdata;
            end else if (FILL_W'(raddr_b) >= fill_reg) begin
                rdata_b_reg <= '0;
            end else begin
                rdata_b_reg <= mem[raddr_b];
            end
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

>>> hdl/gdds_stencil_core.sv
// ----------------------------------------------------------------------------
// gdds_stencil_core
// Five-point diffusion datapath: neighbor sum minus count times centre,
// scaled by the Q2.14 gain, rounded to Q0.16, added to the centre, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module gdds_stencil_core
    import gdds_pkg::*;
(
    input  wire logic      [DENS_W-1:0] old_dens,
    input  wire logic      [DENS_W-1:0] left_dens,
    input  wire logic      [DENS_W-1:0] right_dens,
    input  wire logic      [DENS_W-1:0] up_dens,
    input  wire logic      [DENS_W-1:0] down_dens,
    input  wire gdds_nbr_t              nbr,
    input  wire logic      [GAIN_W-1:0] gain,
    output logic           [DENS_W-1:0] new_dens
);

    localparam int NSUM_W = DENS_W + 2;
    localparam int DIFF_W = NSUM_W + 1;
    localparam int PROD_W = GAIN_W + 1 + DIFF_W;
    localparam int FRAC_W = 14;
    localparam int Q_W    = PROD_W - FRAC_W;
    localparam int V_W    = Q_W + 1;

    localparam logic [2:0] CNT_NONE  = 3'd0;
    localparam logic [2:0] CNT_ONE   = 3'd1;
    localparam logic [2:0] CNT_TWO   = 3'd2;
    localparam logic [2:0] CNT_THREE = 3'd3;
    localparam logic [2:0] CNT_FOUR  = 3'd4;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));

    logic        [NSUM_W-1:0] nbr_sum;
    logic        [2:0]        nbr_cnt;
    logic        [NSUM_W-1:0] old_scaled;
    logic signed [DIFF_W-1:0] diff;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [Q_W-1:0]    step_q;
    logic signed [DENS_W:0]   old_s;
    logic signed [V_W-1:0]    sum_v;

    // Sum the interior neighbors and count them
    always_comb begin
        nbr_sum = (nbr.left  ? NSUM_W'(left_dens)  : '0)
                + (nbr.right ? NSUM_W'(right_dens) : '0)
                + (nbr.up    ? NSUM_W'(up_dens)    : '0)
                + (nbr.down  ? NSUM_W'(down_dens)  : '0);
        nbr_cnt = 3'(nbr.left) + 3'(nbr.right) + 3'(nbr.up) + 3'(nbr.down);
    end

    // Scale the centre by the neighbor count
    always_comb begin
        unique case (nbr_cnt)
            CNT_NONE:  old_scaled = '0;
            CNT_ONE:   old_scaled = NSUM_W'(old_dens);
            CNT_TWO:   old_scaled = NSUM_W'(old_dens) << 1;
            CNT_THREE: old_scaled = (NSUM_W'(old_dens) << 1) + NSUM_W'(old_dens);
            CNT_FOUR:  old_scaled = NSUM_W'(old_dens) << 2;
            default:   old_scaled = '0;
        endcase
    end

    // Laplacian times gain, rounded half up to Q0.16, added to the centre, then saturate
    always_comb begin
        diff     = signed'({1'b0, nbr_sum}) - signed'({1'b0, old_scaled});
        gain_s   = signed'({1'b0, gain});
        prod     = gain_s * diff;
        prod_rnd = prod + ROUND_HALF;
        step_q   = signed'(prod_rnd[PROD_W-1:FRAC_W]);
        old_s    = signed'({1'b0, old_dens});
        sum_v    = step_q + old_s;
        if (sum_v[V_W-1]) begin
            new_dens = '0;
        end else if (|sum_v[V_W-2:DENS_W]) begin
            new_dens = '1;
        end else begin
            new_dens = sum_v[DENS_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> hdl/grid_density_diffusion_stencil_unit.sv
// A result beat follows the beat of the cell directly below it: the memory reads and the input
//   register load on the accepting edge, then the result register loads unless a result still waits.
// Throughput: one cell per clock, set by the combinational stencil path and the
//   two read ports of each row store; the input stalls only while a result waits.
// Reset (aresetn low, synchronous): clears position counters, valid flags and row store
//   fill counts, and loads interior_size 64 and diffusion_gain 1638; no clearing pass.
// ----------------------------------------------------------------------------
// grid_density_diffusion_stencil_unit
// Streaming explicit 2-D diffusion over a bordered square grid with two row
// stores; emits each interior cell one row late with its interior position.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_density_diffusion_stencil_unit
    import gdds_pkg::*;
#(
    parameter int GRID_MAX = GRID_MAX_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input cells
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] cell_density
    input  wire logic                  s_tuser,   // [0] frame_start
    // results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [39:0]           m_tdata,   // [15:0] new_density, [24:16] cell_column,
                                                  // [33:25] cell_row, [39:34] zero
    output logic                       m_tlast    // last_cell
);

    localparam int DEPTH     = GRID_MAX + 2;
    localparam int POS_W     = $clog2(DEPTH);
    localparam int CMP_W     = $clog2(DEPTH + 1);
    localparam int EXT_W     = ((CMP_W > SIZE_W) ? CMP_W : SIZE_W) + 1;
    localparam int M_TDATA_W = ((DENS_W + 2 * SIZE_W + 7) / 8) * 8;

    // Configuration registers
    logic [SIZE_W-1:0] interior_size_reg;
    logic [GAIN_W-1:0] diffusion_gain_reg;

    // Position of the next arriving cell
    logic [POS_W-1:0]  col_pos_reg, col_pos_next;
    logic [POS_W-1:0]  row_pos_reg, row_pos_next;

    // Input register stage
    logic              st1_valid_reg;
    logic              st1_emit_reg;
    logic              st1_last_reg;
    gdds_nbr_t         st1_nbr_reg;
    logic [POS_W-1:0]  st1_addr_reg;
    logic [SIZE_W-1:0] st1_col_reg;
    logic [SIZE_W-1:0] st1_row_reg;
    logic [DENS_W-1:0] st1_dens_reg;

    // Result register
    logic              m_tvalid_reg;
    logic              m_last_reg;
    logic [DENS_W-1:0] m_dens_reg;
    logic [SIZE_W-1:0] m_col_reg;
    logic [SIZE_W-1:0] m_row_reg;

    logic              s_acc;
    logic              st1_adv;
    logic              m_load;
    logic [EXT_W-1:0]  size_ext;
    logic [CMP_W-1:0]  n_eff;
    logic [CMP_W-1:0]  n_p1;
    logic [CMP_W-1:0]  n_p2;
    logic [POS_W-1:0]  c_cur;
    logic [POS_W-1:0]  r_cur;
    logic [CMP_W-1:0]  c_ext;
    logic [CMP_W-1:0]  r_ext;
    logic [CMP_W-1:0]  j_ext;
    logic [CMP_W-1:0]  c_inc;
    logic [CMP_W-1:0]  r_inc;
    logic              in_emit;
    logic              in_last;
    gdds_nbr_t         in_nbr;
    logic [POS_W-1:0]  left_addr;
    logic [POS_W-1:0]  right_addr;
    logic [DENS_W-1:0] up_q;
    logic [DENS_W-1:0] left_q;
    logic [DENS_W-1:0] centre_q;
    logic [DENS_W-1:0] right_q;
    logic [DENS_W-1:0] new_dens;

    // Handshake
    assign st1_adv  = st1_valid_reg && (!st1_emit_reg || !m_tvalid_reg || m_tready);
    assign s_tready = !st1_valid_reg || st1_adv;
    assign s_acc    = s_tvalid && s_tready;
    assign m_load   = st1_adv && st1_emit_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interior_size_reg  <= SIZE_RESET;
            diffusion_gain_reg <= GAIN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_INTERIOR_SIZE:  interior_size_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_DIFFUSION_GAIN: diffusion_gain_reg <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the interior size to 2..GRID_MAX
    always_comb begin
        size_ext = EXT_W'(interior_size_reg);
        if (size_ext < EXT_W'(SIZE_MIN)) begin
            n_eff = CMP_W'(SIZE_MIN);
        end else if (size_ext > EXT_W'(GRID_MAX)) begin
            n_eff = CMP_W'(GRID_MAX);
        end else begin
            n_eff = CMP_W'(size_ext);
        end
        n_p1 = n_eff + CMP_W'(1);
        n_p2 = n_eff + CMP_W'(2);
    end

    // Current cell position, stencil flags and next position
    always_comb begin
        c_cur = s_tuser ? '0 : col_pos_reg;
        r_cur = s_tuser ? '0 : row_pos_reg;
        c_ext = CMP_W'(c_cur);
        r_ext = CMP_W'(r_cur);
        j_ext = r_ext - CMP_W'(1);

        in_emit = (r_ext >= CMP_W'(2)) && (r_ext <= n_p1)
               && (c_ext >= CMP_W'(1)) && (c_ext <= n_eff);
        in_nbr.left  = c_ext > CMP_W'(1);
        in_nbr.right = c_ext < n_eff;
        in_nbr.up    = j_ext > CMP_W'(1);
        in_nbr.down  = j_ext < n_eff;
        in_last      = (c_ext == n_eff) && (j_ext == n_eff);

        c_inc = c_ext + CMP_W'(1);
        r_inc = r_ext;
        if (c_inc >= n_p2) begin
            c_inc = '0;
            r_inc = r_ext + CMP_W'(1);
            if (r_inc >= n_p2) begin
                r_inc = '0;
            end
        end
        if (r_inc >= n_p2) begin
            r_inc = '0;
        end
        col_pos_next = POS_W'(c_inc);
        row_pos_next = POS_W'(r_inc);
    end

    // Neighbor addresses in the row stores
    assign left_addr  = (c_cur == '0) ? '0 : c_cur - POS_W'(1);
    assign right_addr = (c_cur == POS_W'(DEPTH - 1)) ? c_cur : c_cur + POS_W'(1);

    // Advance position on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end else if (s_acc) begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

    // Input register: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            st1_valid_reg <= 1'b1;
        end else if (st1_adv) begin
            st1_valid_reg <= 1'b0;
        end
    end

    // Input register: payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            st1_emit_reg <= in_emit;
            st1_last_reg <= in_last;
            st1_nbr_reg  <= in_nbr;
            st1_addr_reg <= c_cur;
            st1_col_reg  <= SIZE_W'(c_ext);
            st1_row_reg  <= SIZE_W'(j_ext);
            st1_dens_reg <= s_tdata[DENS_W-1:0];
        end
    end

    // Upper row store: up and left neighbors; takes the old centre
    gdds_row_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (DENS_W)
    ) u_upper_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (st1_adv),
        .waddr   (st1_addr_reg),
        .wdata   (centre_q),
        .re      (s_acc),
        .raddr_a (c_cur),
        .raddr_b (left_addr),
        .rdata_a (up_q),
        .rdata_b (left_q)
    );

    // Middle row store: centre and right neighbor; takes the arriving cell
    gdds_row_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (DENS_W)
    ) u_middle_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (st1_adv),
        .waddr   (st1_addr_reg),
        .wdata   (st1_dens_reg),
        .re      (s_acc),
        .raddr_a (c_cur),
        .raddr_b (right_addr),
        .rdata_a (centre_q),
        .rdata_b (right_q)
    );

    // Stencil arithmetic
    gdds_stencil_core u_core (
        .old_dens   (centre_q),
        .left_dens  (left_q),
        .right_dens (right_q),
        .up_dens    (up_q),
        .down_dens  (st1_dens_reg),
        .nbr        (st1_nbr_reg),
        .gain       (diffusion_gain_reg),
        .new_dens   (new_dens)
    );

    // Result register: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (m_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_dens_reg <= new_dens;
            m_col_reg  <= st1_col_reg;
            m_row_reg  <= st1_row_reg;
            m_last_reg <= st1_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_row_reg, m_col_reg, m_dens_reg});
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // An accepted beat always lands in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> st1_valid_reg)
        else $error("accepted beat did not reach the input register");

    // The final cell sits on the diagonal
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[24:16] == m_tdata[33:25])
        else $error("last_cell on an off-diagonal cell");

    // Results are interior cells only
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[24:16] != 9'd0) && (m_tdata[33:25] != 9'd0))
        else $error("result emitted for a border cell");
`endif

endmodule

`default_nettype wire
